// File: rtl/dtse_pkg.sv
// ----------------------------------------------------------------------------
// dtse_pkg: shared definitions for the date/time set editor
// Operation and key codes, field widths, reset values and the month limit.
// ----------------------------------------------------------------------------
package dtse_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int KEY_W    = 3;
    localparam int YEAR_W   = 7;
    localparam int MONTH_W  = 4;
    localparam int LDAY_W   = 5;
    localparam int DAY_W    = 6;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEL_W    = 3;
    localparam int PERIOD_W = 16;
    localparam int REG_W    = 8;   // calendar register width
    localparam int LIM_W    = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_KEY  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd2;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_MODE = 3'd1;
    localparam logic [KEY_W-1:0] KEY_NEXT = 3'd2;
    localparam logic [KEY_W-1:0] KEY_INC  = 3'd3;
    localparam logic [KEY_W-1:0] KEY_DEC  = 3'd4;

    // Field selector codes
    localparam logic [SEL_W-1:0] SEL_YEAR   = 3'd0;
    localparam logic [SEL_W-1:0] SEL_MONTH  = 3'd1;
    localparam logic [SEL_W-1:0] SEL_DAY    = 3'd2;
    localparam logic [SEL_W-1:0] SEL_HOUR   = 3'd3;
    localparam logic [SEL_W-1:0] SEL_MINUTE = 3'd4;
    localparam logic [SEL_W-1:0] SEL_SECOND = 3'd5;

    // Limits and reset values
    localparam logic [REG_W-1:0]    YEAR_MAX    = 8'd99;
    localparam logic [REG_W-1:0]    MONTH_MAX   = 8'd12;
    localparam logic [REG_W-1:0]    HOUR_MAX    = 8'd23;
    localparam logic [REG_W-1:0]    MINSEC_MAX  = 8'd59;
    localparam logic [REG_W-1:0]    REG_ALL_ONE = 8'd255;
    localparam logic [PERIOD_W-1:0] BLINK_RESET = 16'd700;

    // Days in a month; zero for a month code outside 1..12
    function automatic logic [LIM_W-1:0] month_limit(input logic [REG_W-1:0]  month,
                                                      input logic [YEAR_W-1:0] year);
        logic [LIM_W-1:0] lim;
        case (month)
            8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: lim = 5'd31;
            8'd4, 8'd6, 8'd9, 8'd11:                    lim = 5'd30;
            8'd2:    lim = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
            default: lim = 5'd0;
        endcase
        return lim;
    endfunction

endpackage

// File: rtl/date_time_set_editor.sv
// ----------------------------------------------------------------------------
// date_time_set_editor: calendar set editor with blink timing
// Holds year/month/day/hour/minute/second, handles mode, field select,
// step up/down with per-field wrap and clamp, time loads and blink ticks.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready  | op, key code, load fields
//  out     | output    | o_out_valid / i_out_ready| mode, select, blink, commit, time
//  cfg     | input     | i_cfg_we                 | blink period (16 bit)
//
//  One beat per cycle while the out channel is not stalled: each accepted beat
//  sets the calendar state registers, and its result is shown on the next cycle.
//  The in channel is ready whenever the result register is empty or being taken,
//  so a stalled out channel stalls the in channel with no loss.
//  Synchronous active-low reset: year 0, month 1, day 1, 00:00:00, display
//  mode, period 700.
// ----------------------------------------------------------------------------
module date_time_set_editor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config
    input  logic                          i_cfg_we,
    input  logic [dtse_pkg::PERIOD_W-1:0] i_cfg_wdata,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dtse_pkg::OP_W-1:0]     i_operation,
    input  logic [dtse_pkg::KEY_W-1:0]    i_key_code,
    input  logic [dtse_pkg::YEAR_W-1:0]   i_load_year,
    input  logic [dtse_pkg::MONTH_W-1:0]  i_load_month,
    input  logic [dtse_pkg::LDAY_W-1:0]   i_load_day,
    input  logic [dtse_pkg::HOUR_W-1:0]   i_load_hour,
    input  logic [dtse_pkg::MIN_W-1:0]    i_load_minute,
    input  logic [dtse_pkg::MIN_W-1:0]    i_load_second,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_edit_mode,
    output logic [dtse_pkg::SEL_W-1:0]    o_selected_field,
    output logic                          o_blink_on,
    output logic                          o_commit,
    output logic [dtse_pkg::YEAR_W-1:0]   o_out_year,
    output logic [dtse_pkg::MONTH_W-1:0]  o_out_month,
    output logic [dtse_pkg::DAY_W-1:0]    o_out_day,
    output logic [dtse_pkg::HOUR_W-1:0]   o_out_hour,
    output logic [dtse_pkg::MIN_W-1:0]    o_out_minute,
    output logic [dtse_pkg::MIN_W-1:0]    o_out_second
);
    import dtse_pkg::*;

    // State registers
    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] r_count,  n_count;
    logic                r_edit,   n_edit;
    logic [SEL_W-1:0]    r_sel,    n_sel;
    logic                r_blink,  n_blink;
    logic                r_commit, n_commit;
    logic                r_out_valid;
    logic [YEAR_W-1:0]   r_year,   n_year;
    logic [REG_W-1:0]    r_month,  n_month;
    logic [REG_W-1:0]    r_day,    n_day;
    logic [HOUR_W-1:0]   r_hour,   n_hour;
    logic [MIN_W-1:0]    r_minute, n_minute;
    logic [MIN_W-1:0]    r_second, n_second;

    logic                in_accept;
    logic [PERIOD_W:0]   count_inc;
    logic [REG_W-1:0]    s_year, s_month, s_day, s_hour, s_minute, s_second;
    logic [REG_W-1:0]    c_month;
    logic [YEAR_W-1:0]   c_year;
    logic [LIM_W-1:0]    lim;
    logic [REG_W-1:0]    lim_ext;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign count_inc  = {1'b0, r_count} + {{PERIOD_W{1'b0}}, 1'b1};

    // Step the selected field by one, up or down, in register width
    always_comb begin
        s_year   = {1'b0, r_year};
        s_month  = r_month;
        s_day    = r_day;
        s_hour   = {{(REG_W-HOUR_W){1'b0}}, r_hour};
        s_minute = {{(REG_W-MIN_W){1'b0}}, r_minute};
        s_second = {{(REG_W-MIN_W){1'b0}}, r_second};
        case (r_sel)
            SEL_YEAR:   s_year   = (i_key_code == KEY_INC) ? s_year + 8'd1   : s_year - 8'd1;
            SEL_MONTH:  s_month  = (i_key_code == KEY_INC) ? s_month + 8'd1  : s_month - 8'd1;
            SEL_DAY:    s_day    = (i_key_code == KEY_INC) ? s_day + 8'd1    : s_day - 8'd1;
            SEL_HOUR:   s_hour   = (i_key_code == KEY_INC) ? s_hour + 8'd1   : s_hour - 8'd1;
            SEL_MINUTE: s_minute = (i_key_code == KEY_INC) ? s_minute + 8'd1 : s_minute - 8'd1;
            SEL_SECOND: s_second = (i_key_code == KEY_INC) ? s_second + 8'd1 : s_second - 8'd1;
            default: ;
        endcase
    end

    // Year and month after their wrap, feeding the day limit
    always_comb begin
        if (i_key_code == KEY_INC) begin
            c_year  = (s_year > YEAR_MAX) ? 7'd0 : s_year[YEAR_W-1:0];
            c_month = (s_month > MONTH_MAX) ? 8'd1 : s_month;
        end else begin
            c_year  = (s_year == REG_ALL_ONE) ? YEAR_MAX[YEAR_W-1:0] : s_year[YEAR_W-1:0];
            c_month = (s_month == 8'd0) ? MONTH_MAX : s_month;
        end
    end

    assign lim     = month_limit(c_month, c_year);
    assign lim_ext = {{(REG_W-LIM_W){1'b0}}, lim};

    // Next state for one accepted beat
    always_comb begin
        n_count  = r_count;
        n_edit   = r_edit;
        n_sel    = r_sel;
        n_blink  = r_blink;
        n_commit = 1'b0;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        case (i_operation)
            OP_TICK: begin
                if (count_inc >= {1'b0, r_period}) begin
                    n_count = '0;
                    if (r_edit) n_blink = !r_blink;
                end else begin
                    n_count = count_inc[PERIOD_W-1:0];
                end
            end
            OP_KEY: begin
                if (i_key_code == KEY_MODE) begin
                    if (!r_edit) begin
                        n_edit = 1'b1;
                        n_sel  = SEL_YEAR;
                    end else begin
                        n_edit   = 1'b0;
                        n_commit = 1'b1;
                    end
                end else if (r_edit && i_key_code == KEY_NEXT) begin
                    n_sel = (r_sel == SEL_SECOND) ? SEL_YEAR : r_sel + 3'd1;
                end else if (r_edit && i_key_code == KEY_INC) begin
                    n_year   = c_year;
                    n_month  = c_month;
                    n_day    = (lim != 5'd0 && s_day > lim_ext) ? 8'd1 : s_day;
                    n_hour   = (s_hour > HOUR_MAX) ? 5'd0 : s_hour[HOUR_W-1:0];
                    n_minute = (s_minute > MINSEC_MAX) ? 6'd0 : s_minute[MIN_W-1:0];
                    n_second = (s_second > MINSEC_MAX) ? 6'd0 : s_second[MIN_W-1:0];
                end else if (r_edit && i_key_code == KEY_DEC) begin
                    n_year  = c_year;
                    n_month = c_month;
                    n_day   = s_day;
                    if (lim == 5'd31) begin
                        if (s_day == 8'd0) n_day = lim_ext;
                    end else if (lim != 5'd0) begin
                        if (s_day == 8'd0 || s_day > lim_ext) n_day = lim_ext;
                    end
                    n_hour   = (s_hour == REG_ALL_ONE) ? HOUR_MAX[HOUR_W-1:0]
                                                       : s_hour[HOUR_W-1:0];
                    n_minute = (s_minute == REG_ALL_ONE) ? MINSEC_MAX[MIN_W-1:0]
                                                         : s_minute[MIN_W-1:0];
                    n_second = (s_second == REG_ALL_ONE) ? MINSEC_MAX[MIN_W-1:0]
                                                         : s_second[MIN_W-1:0];
                end
            end
            OP_LOAD: begin
                if (!r_edit) begin
                    n_year   = i_load_year;
                    n_month  = {{(REG_W-MONTH_W){1'b0}}, i_load_month};
                    n_day    = {{(REG_W-LDAY_W){1'b0}}, i_load_day};
                    n_hour   = i_load_hour;
                    n_minute = i_load_minute;
                    n_second = i_load_second;
                end
            end
            default: ;
        endcase
    end

    // Register state on each accepted beat; hold the result while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= BLINK_RESET;
            r_count     <= '0;
            r_edit      <= 1'b0;
            r_sel       <= SEL_YEAR;
            r_blink     <= 1'b0;
            r_commit    <= 1'b0;
            r_out_valid <= 1'b0;
            r_year      <= '0;
            r_month     <= 8'd1;
            r_day       <= 8'd1;
            r_hour      <= '0;
            r_minute    <= '0;
            r_second    <= '0;
        end else begin
            if (i_cfg_we) r_period <= i_cfg_wdata;
            if (in_accept) begin
                r_count  <= n_count;
                r_edit   <= n_edit;
                r_sel    <= n_sel;
                r_blink  <= n_blink;
                r_commit <= n_commit;
                r_year   <= n_year;
                r_month  <= n_month;
                r_day    <= n_day;
                r_hour   <= n_hour;
                r_minute <= n_minute;
                r_second <= n_second;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Drive the result beat from the state registers
    assign o_out_valid      = r_out_valid;
    assign o_edit_mode      = r_edit;
    assign o_selected_field = r_sel;
    assign o_blink_on       = r_blink && r_edit;
    assign o_commit         = r_commit;
    assign o_out_year       = r_year;
    assign o_out_month      = r_month[MONTH_W-1:0];
    assign o_out_day        = r_day[DAY_W-1:0];
    assign o_out_hour       = r_hour;
    assign o_out_minute     = r_minute;
    assign o_out_second     = r_second;

`ifndef SYNTHESIS
    a_commit_leaves_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_commit |-> !r_edit)
        else $error("commit raised while still in edit mode");

    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel <= SEL_SECOND)
        else $error("selected field out of range");

    a_load_ignored_in_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_operation == OP_LOAD && r_edit |=>
        $stable(r_year) && $stable(r_month) && $stable(r_day) &&
        $stable(r_hour) && $stable(r_minute) && $stable(r_second))
        else $error("time load changed registers in edit mode");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_edit) && $stable(r_sel) &&
        $stable(r_count) && $stable(r_day))
        else $error("state advanced while result stalled");
`endif

endmodule
